FILE: sv/aod_pkg.sv
// aod_pkg: shared types, register indexes and reset values for the
// accelerometer orientation detector. No dependencies.
`timescale 1ns / 1ps

package aod_pkg;

   localparam int AXIS_W  = 32;
   localparam int SQ_W    = 2 * AXIS_W;
   localparam int TAN_W   = 16;
   localparam int ORI_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_SHIFT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_BITS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_SIGNED    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PORTRAIT_TAN_SQ  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LANDSCAPE_TAN_SQ = 3'd4;

   // register reset values
   localparam logic [4:0]       RST_SAMPLE_SHIFT     = 5'd0;
   localparam logic [5:0]       RST_SAMPLE_BITS      = 6'd16;
   localparam logic             RST_SAMPLE_SIGNED    = 1'b1;
   localparam logic [TAN_W-1:0] RST_PORTRAIT_TAN_SQ  = 16'd9161;
   localparam logic [TAN_W-1:0] RST_LANDSCAPE_TAN_SQ = 16'd14910;

   // orientation codes
   localparam logic [ORI_W-1:0] ORI_UNDEFINED = 3'd0;
   localparam logic [ORI_W-1:0] ORI_NORMAL    = 3'd1;
   localparam logic [ORI_W-1:0] ORI_BOTTOM_UP = 3'd2;
   localparam logic [ORI_W-1:0] ORI_LEFT_UP   = 3'd3;
   localparam logic [ORI_W-1:0] ORI_RIGHT_UP  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_MUL_P,
      ST_CMP_P,
      ST_MUL_L,
      ST_CMP_L,
      ST_OUT
   } state_type;

   // merge stage control, driven by the top-level sequencer
   typedef struct packed {
      logic sum_en;
      logic mul_en;
      logic cmp_en;
      logic sel_land;
   } mctl_type;

endpackage

FILE: sv/aod_req_if.sv
// aod_req_if: request channel carrying three raw axis words.
// Depends on aod_pkg for the axis width.
`timescale 1ns / 1ps

interface aod_req_if;
   logic                          valid;
   logic                          ready;
   logic [aod_pkg::AXIS_W-1:0]    raw_x;
   logic [aod_pkg::AXIS_W-1:0]    raw_y;
   logic [aod_pkg::AXIS_W-1:0]    raw_z;

   modport source (output valid, raw_x, raw_y, raw_z, input ready);
   modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

FILE: sv/aod_rsp_if.sv
// aod_rsp_if: result channel carrying orientation and decoded axes.
// Depends on aod_pkg for field widths.
`timescale 1ns / 1ps

interface aod_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [aod_pkg::ORI_W-1:0]            orientation;
   logic                                 orientation_changed;
   logic signed [aod_pkg::AXIS_W-1:0]    accel_x;
   logic signed [aod_pkg::AXIS_W-1:0]    accel_y;
   logic signed [aod_pkg::AXIS_W-1:0]    accel_z;

   modport source (output valid, orientation, orientation_changed,
                   accel_x, accel_y, accel_z, input ready);
   modport sink   (input valid, orientation, orientation_changed,
                   accel_x, accel_y, accel_z, output ready);
endinterface

FILE: sv/aod_lane.sv
// aod_lane: one axis lane - unpack, optional negate, then square.
// Depends on aod_pkg.
`timescale 1ns / 1ps

module aod_lane (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          negate,
   input  logic [aod_pkg::AXIS_W-1:0]    raw,
   input  logic [4:0]                    sample_shift,
   input  logic [5:0]                    sample_bits,
   input  logic                          sample_signed,
   output logic [aod_pkg::AXIS_W-1:0]    value,
   output logic [aod_pkg::SQ_W-1:0]      square
);

   logic [aod_pkg::AXIS_W-1:0] shifted;
   logic [aod_pkg::AXIS_W-1:0] mask;
   logic [aod_pkg::AXIS_W-1:0] kept;
   logic [aod_pkg::AXIS_W-1:0] dec_in;
   logic [aod_pkg::AXIS_W-1:0] dec_ff;
   logic [aod_pkg::AXIS_W-1:0] mag;
   logic [aod_pkg::SQ_W-1:0]   sq_in;
   logic [aod_pkg::SQ_W-1:0]   sq_ff;
   logic                       full_width;
   logic [4:0]                 sign_idx;

   always_comb begin
      if (sample_signed) begin
         shifted = 32'($signed(raw) >>> sample_shift);
      end else begin
         shifted = raw >> sample_shift;
      end
      // counts of 32 and above keep the whole word
      full_width = (sample_bits >= 6'd32);
      mask       = full_width ? '1 : ~(32'hFFFF_FFFF << sample_bits[4:0]);
      sign_idx   = full_width ? 5'd31 : 5'(sample_bits - 6'd1);
      if (sample_signed && shifted[sign_idx]) begin
         kept = shifted | ~mask;
      end else begin
         kept = shifted & mask;
      end
      if (sample_bits == 6'd0) begin
         kept = '0;
      end
      dec_in = negate ? (32'd0 - kept) : kept;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dec_ff <= dec_in;
      end
   end

   // magnitude of the most negative value is 2^31, still fits unsigned
   assign mag   = dec_ff[aod_pkg::AXIS_W-1] ? (32'd0 - dec_ff) : dec_ff;
   assign sq_in = mag * mag;

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign value  = dec_ff;
   assign square = sq_ff;

endmodule

FILE: sv/aod_merge.sv
// aod_merge: combine lane squares into the portrait and landscape tilt
// tests on a shared 64x16 multiplier split in two halves. Depends on aod_pkg.
`timescale 1ns / 1ps

module aod_merge (
   input  logic                          clock,
   input  aod_pkg::mctl_type             ctl,
   input  logic [aod_pkg::SQ_W-1:0]      xx,
   input  logic [aod_pkg::SQ_W-1:0]      yy,
   input  logic [aod_pkg::SQ_W-1:0]      zz,
   input  logic [aod_pkg::AXIS_W-1:0]    x_val,
   input  logic [aod_pkg::AXIS_W-1:0]    y_val,
   input  logic [aod_pkg::TAN_W-1:0]     portrait_tan_sq,
   input  logic [aod_pkg::TAN_W-1:0]     landscape_tan_sq,
   input  logic [aod_pkg::ORI_W-1:0]     last_ori,
   output logic [aod_pkg::ORI_W-1:0]     orientation
);

   localparam int HALF_W = aod_pkg::SQ_W / 2;
   localparam int PP_W   = HALF_W + aod_pkg::TAN_W;
   localparam int PROD_W = aod_pkg::SQ_W + aod_pkg::TAN_W;

   logic [aod_pkg::SQ_W-1:0]  sum_p_ff;
   logic [aod_pkg::SQ_W-1:0]  sum_l_ff;
   logic [aod_pkg::SQ_W-1:0]  mul_src;
   logic [aod_pkg::TAN_W-1:0] mul_tan;
   logic [PP_W-1:0]           plo_ff;
   logic [PP_W-1:0]           phi_ff;
   logic [PROD_W-1:0]         rhs;
   logic [PROD_W-1:0]         lhs;
   logic                      ge;
   logic                      hit_p_ff;
   logic                      hit_l_ff;

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         sum_p_ff <= yy + zz;
         sum_l_ff <= xx + zz;
      end
   end

   assign mul_src = ctl.sel_land ? sum_l_ff : sum_p_ff;
   assign mul_tan = ctl.sel_land ? landscape_tan_sq : portrait_tan_sq;

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         plo_ff <= mul_src[HALF_W-1:0] * mul_tan;
         phi_ff <= mul_src[aod_pkg::SQ_W-1:HALF_W] * mul_tan;
      end
   end

   assign rhs = {phi_ff, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, plo_ff};
   assign lhs = ctl.sel_land ? {yy, {aod_pkg::TAN_W{1'b0}}}
                             : {xx, {aod_pkg::TAN_W{1'b0}}};
   assign ge  = (lhs >= rhs);

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         if (ctl.sel_land) begin
            hit_l_ff <= ge;
         end else begin
            hit_p_ff <= ge;
         end
      end
   end

   // portrait wins over landscape; neither keeps the held orientation
   always_comb begin
      orientation = last_ori;
      if ((x_val != '0) && hit_p_ff) begin
         orientation = x_val[aod_pkg::AXIS_W-1] ? aod_pkg::ORI_LEFT_UP
                                                : aod_pkg::ORI_RIGHT_UP;
      end else if ((y_val != '0) && hit_l_ff) begin
         orientation = y_val[aod_pkg::AXIS_W-1] ? aod_pkg::ORI_BOTTOM_UP
                                                : aod_pkg::ORI_NORMAL;
      end
   end

endmodule

FILE: sv/accel_orientation_detect.sv
// accel_orientation_detect: top level - configuration registers, request
// sequencer, three axis lanes, merge stage and response register.
// Depends on aod_pkg, aod_req_if, aod_rsp_if, aod_lane and aod_merge.
`timescale 1ns / 1ps

// Screen orientation from one accelerometer sample per request. Each raw
// axis word is unpacked (shift, bit count, optional sign extension), x and y
// are negated, and the tilt tests run as exact squared compares against the
// Q16 tan^2 thresholds: portrait first (left-up / right-up), then landscape
// (bottom-up / normal), else the held orientation stays. The lanes unpack a
// request at its accepting edge; then come the per-lane 32x32 square, the
// sums, two multiply and compare passes, each a multiply step then a compare
// step, through the single shared 64x16 multiplier (split into two 32x16
// halves), and last the load of the response register. The next request is
// accepted once the sequencer is back in idle after that load. A response
// that is still unclaimed when the next one is ready holds the sequencer
// until it is taken. The block works on one request at a time; while a
// response waits in the output register, the next request is still
// accepted. Configuration may be written only while the block is idle.
// Register indexes: 0 sample_shift, 1 sample_bits, 2 sample_signed,
// 3 portrait_tan_sq, 4 landscape_tan_sq; other indexes are ignored and write
// data is cut to each register's width.

module accel_orientation_detect (
   input  logic                              clock,
   input  logic                              reset,
   aod_req_if.sink                           req_if,
   aod_rsp_if.source                         rsp_if,
   input  logic                              csr_wr_en,
   input  logic [aod_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aod_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic [4:0]                 shift_ff;
   logic [5:0]                 bits_ff;
   logic                       signed_ff;
   logic [aod_pkg::TAN_W-1:0]  ptan_ff;
   logic [aod_pkg::TAN_W-1:0]  ltan_ff;

   // sequencer and held orientation
   aod_pkg::state_type         state_ff;
   aod_pkg::state_type         state_in;
   logic [aod_pkg::ORI_W-1:0]  last_ori_ff;
   logic [aod_pkg::ORI_W-1:0]  last_ori_in;
   aod_pkg::mctl_type          mctl;

   // response register
   logic                       out_full_ff;
   logic                       out_full_in;
   logic                       out_load;
   logic [aod_pkg::ORI_W-1:0]  out_ori_ff;
   logic                       out_chg_ff;
   logic [aod_pkg::AXIS_W-1:0] out_x_ff;
   logic [aod_pkg::AXIS_W-1:0] out_y_ff;
   logic [aod_pkg::AXIS_W-1:0] out_z_ff;

   // lane results
   logic                       req_take;
   logic                       rsp_take;
   logic [aod_pkg::AXIS_W-1:0] x_val;
   logic [aod_pkg::AXIS_W-1:0] y_val;
   logic [aod_pkg::AXIS_W-1:0] z_val;
   logic [aod_pkg::SQ_W-1:0]   xx;
   logic [aod_pkg::SQ_W-1:0]   yy;
   logic [aod_pkg::SQ_W-1:0]   zz;
   logic [aod_pkg::ORI_W-1:0]  new_ori;

   // configuration writes, masked to each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff  <= aod_pkg::RST_SAMPLE_SHIFT;
         bits_ff   <= aod_pkg::RST_SAMPLE_BITS;
         signed_ff <= aod_pkg::RST_SAMPLE_SIGNED;
         ptan_ff   <= aod_pkg::RST_PORTRAIT_TAN_SQ;
         ltan_ff   <= aod_pkg::RST_LANDSCAPE_TAN_SQ;
      end else if (csr_wr_en) begin
         case (csr_index)
            aod_pkg::CSR_SAMPLE_SHIFT:     shift_ff  <= csr_wdata[4:0];
            aod_pkg::CSR_SAMPLE_BITS:      bits_ff   <= csr_wdata[5:0];
            aod_pkg::CSR_SAMPLE_SIGNED:    signed_ff <= csr_wdata[0];
            aod_pkg::CSR_PORTRAIT_TAN_SQ:  ptan_ff   <= csr_wdata;
            aod_pkg::CSR_LANDSCAPE_TAN_SQ: ltan_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // accept a request only between requests; a pending response does not block
   assign req_if.ready = (state_ff == aod_pkg::ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign rsp_take     = rsp_if.valid && rsp_if.ready;

   // three lanes unpack and square their axis side by side
   aod_lane u_lane_x (
      .clock         (clock),
      .load          (req_take),
      .negate        (1'b1),
      .raw           (req_if.raw_x),
      .sample_shift  (shift_ff),
      .sample_bits   (bits_ff),
      .sample_signed (signed_ff),
      .value         (x_val),
      .square        (xx)
   );

   aod_lane u_lane_y (
      .clock         (clock),
      .load          (req_take),
      .negate        (1'b1),
      .raw           (req_if.raw_y),
      .sample_shift  (shift_ff),
      .sample_bits   (bits_ff),
      .sample_signed (signed_ff),
      .value         (y_val),
      .square        (yy)
   );

   aod_lane u_lane_z (
      .clock         (clock),
      .load          (req_take),
      .negate        (1'b0),
      .raw           (req_if.raw_z),
      .sample_shift  (shift_ff),
      .sample_bits   (bits_ff),
      .sample_signed (signed_ff),
      .value         (z_val),
      .square        (zz)
   );

   aod_merge u_merge (
      .clock            (clock),
      .ctl              (mctl),
      .xx               (xx),
      .yy               (yy),
      .zz               (zz),
      .x_val            (x_val),
      .y_val            (y_val),
      .portrait_tan_sq  (ptan_ff),
      .landscape_tan_sq (ltan_ff),
      .last_ori         (last_ori_ff),
      .orientation      (new_ori)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= aod_pkg::ST_IDLE;
         last_ori_ff <= aod_pkg::ORI_UNDEFINED;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         last_ori_ff <= last_ori_in;
         out_full_ff <= out_full_in;
      end
   end

   // sequencer: step the merge stage through sum, then portrait and
   // landscape multiply/compare, then hand off to the response register
   always_comb begin
      state_in    = state_ff;
      last_ori_in = last_ori_ff;
      mctl        = '0;
      out_load    = 1'b0;
      case (state_ff)
         aod_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = aod_pkg::ST_SQUARE;
            end
         end
         aod_pkg::ST_SQUARE: begin
            state_in = aod_pkg::ST_SUM;
         end
         aod_pkg::ST_SUM: begin
            mctl.sum_en = 1'b1;
            state_in    = aod_pkg::ST_MUL_P;
         end
         aod_pkg::ST_MUL_P: begin
            mctl.mul_en = 1'b1;
            state_in    = aod_pkg::ST_CMP_P;
         end
         aod_pkg::ST_CMP_P: begin
            mctl.cmp_en = 1'b1;
            state_in    = aod_pkg::ST_MUL_L;
         end
         aod_pkg::ST_MUL_L: begin
            mctl.mul_en   = 1'b1;
            mctl.sel_land = 1'b1;
            state_in      = aod_pkg::ST_CMP_L;
         end
         aod_pkg::ST_CMP_L: begin
            mctl.cmp_en   = 1'b1;
            mctl.sel_land = 1'b1;
            state_in      = aod_pkg::ST_OUT;
         end
         aod_pkg::ST_OUT: begin
            // hold here while the previous response is still unclaimed
            if (!out_full_ff || rsp_take) begin
               out_load    = 1'b1;
               last_ori_in = new_ori;
               state_in    = aod_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aod_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_full_in = out_full_ff;
      if (out_load) begin
         out_full_in = 1'b1;
      end else if (rsp_take) begin
         out_full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ori_ff <= new_ori;
         out_chg_ff <= (new_ori != last_ori_ff);
         out_x_ff   <= x_val;
         out_y_ff   <= y_val;
         out_z_ff   <= z_val;
      end
   end

   assign rsp_if.valid               = out_full_ff;
   assign rsp_if.orientation         = out_ori_ff;
   assign rsp_if.orientation_changed = out_chg_ff;
   assign rsp_if.accel_x             = $signed(out_x_ff);
   assign rsp_if.accel_y             = $signed(out_y_ff);
   assign rsp_if.accel_z             = $signed(out_z_ff);

endmodule
